/* hdl/handshake_servo_frame_sender_defines.svh */
// assertion macros for the servo frame sender
// expects clk and arst_n in the scope of each use
`ifndef HANDSHAKE_SERVO_FRAME_SENDER_DEFINES_SVH
`define HANDSHAKE_SERVO_FRAME_SENDER_DEFINES_SVH

// consequent checked in the same cycle
`define HSFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define HSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hsfs_pkg.sv */
// shared types and constants for the servo frame sender
// no dependencies
package hsfs_pkg;

	localparam int OP_W       = 2;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int STATUS_W   = 3;
	localparam int FAIL_E_W   = 4;
	localparam int FAIL_B_W   = 3;
	localparam int OUT_DW     = 16;
	localparam int NUM_CFG    = 4;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_START = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACK_TIMEOUT   = 2'd0,
		CFG_RESET_LOW     = 2'd1,
		CFG_RESET_RECOVER = 2'd2,
		CFG_LATCH_HOLD    = 2'd3
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST   = 16'd1000;
	localparam logic [CFG_W-1:0] RESET_LOW_RST     = 16'd6897;
	localparam logic [CFG_W-1:0] RESET_RECOVER_RST = 16'd34483;
	localparam logic [CFG_W-1:0] LATCH_HOLD_RST    = 16'd3448;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_EMPTY         = 3'd1,
		ST_READY_TIMEOUT = 3'd2,
		ST_ID_BIT        = 3'd3,
		ST_TIME_BIT      = 3'd4,
		ST_FINAL_RISE    = 3'd5,
		ST_FINAL_FALL    = 3'd6,
		ST_COMPLETION    = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_WAIT_READY,
		PH_RESET_LOW,
		PH_RECOVER,
		PH_ACK_HIGH,
		PH_ACK_LOW,
		PH_FINAL_RISE,
		PH_LATCH_HOLD,
		PH_FINAL_FALL,
		PH_WAIT_DONE
	} phase_t;

endpackage

/* hdl/hsfs_entry_ram.sv */
// entry list memory: one write port, one read port with registered data
// no package dependencies
module hsfs_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 11,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/handshake_servo_frame_sender.sv */
// Servo frame sender over a four-wire handshake link. Requests arrive on the s_ side, one
// command each (tick, load entry, start, clear list); every request yields exactly one
// result on the m_ side carrying the link line levels and transfer status after that
// request. When a request is taken, the entry memory is read for the bit its step may
// need; the step is applied once any earlier result has been taken from m_tdata, and its
// result is then offered on m_tdata. A new request is taken only after the held one has
// been stepped, so at most one request waits behind a result not yet taken. Configuration
// writes are accepted any cycle. Depends on hsfs_pkg, hsfs_entry_ram and
// handshake_servo_frame_sender_defines.svh.
`include "handshake_servo_frame_sender_defines.svh"

module handshake_servo_frame_sender #(
	parameter int MAX_ENTRIES = 16,
	parameter int ID_BITS     = 3,
	parameter int TIME_BITS   = 8
) (
	input  logic clk,
	input  logic arst_n,

	// [ID_BITS-1:0] servo_id, then pulse_time, bit_ack, ready_line, zero fill
	input  logic [((ID_BITS+TIME_BITS+2+7)/8)*8-1:0] s_tdata,
	// [1:0] opcode
	input  logic [hsfs_pkg::OP_W-1:0]                 s_tuser,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,

	// [0] clock_out, [1] data_out, [2] request_out, [3] reset_out, [4] busy_res,
	// [5] done_res, [8:6] status_code, [12:9] fail_entry, [15:13] fail_bit
	output logic [hsfs_pkg::OUT_DW-1:0]               m_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,

	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [hsfs_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [hsfs_pkg::CFG_W-1:0]                cfg_data
);

	localparam int NB   = ID_BITS + TIME_BITS;
	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int BW   = $clog2(NB + 1);
	localparam int BIW  = $clog2(NB);

	// request stage
	logic                         v_s1;
	hsfs_pkg::op_t                op_s1;
	logic [ID_BITS-1:0]           id_s1;
	logic [TIME_BITS-1:0]         time_s1;
	logic                         ack_s1;
	logic                         rdy_s1;

	// control state
	hsfs_pkg::phase_t             phase_q, phase_d;
	logic [CW-1:0]                count_q, count_d;
	logic [AW-1:0]                cursor_q, cursor_d;
	logic [BW-1:0]                bit_q, bit_d;
	logic [hsfs_pkg::CFG_W-1:0]   wait_q, wait_d;
	logic                         retried_q, retried_d;
	logic                         clk_q, clk_d, dat_q, dat_d, req_q, req_d, rst_q, rst_d;
	logic [hsfs_pkg::STATUS_W-1:0] status_q, status_d;
	logic [hsfs_pkg::FAIL_E_W-1:0] fail_e_q, fail_e_d;
	logic [hsfs_pkg::FAIL_B_W-1:0] fail_b_q, fail_b_d;
	logic                         done_q, done_d;
	logic                         out_valid_q;
	logic [hsfs_pkg::CFG_W-1:0]   cfg_q [hsfs_pkg::NUM_CFG];

	// step helpers
	logic                         accept, exec_go, is_tick;
	logic                         sample, want, hit, expire, last;
	logic [hsfs_pkg::CFG_W:0]     cnt_inc;
	logic [hsfs_pkg::CFG_W-1:0]   lim;
	logic [BW-1:0]                bit_inc, bit_limit, bit_new;
	logic                         bit_more;
	logic [AW-1:0]                rd_addr;
	logic [NB-1:0]                rd_word;
	logic                         new_bit_val;
	logic                         ram_we;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !v_s1;
	assign exec_go   = v_s1 && (!out_valid_q || m_tready);
	assign is_tick   = (op_s1 == hsfs_pkg::OP_TICK);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (exec_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= hsfs_pkg::op_t'(s_tuser);
			id_s1   <= s_tdata[ID_BITS-1:0];
			time_s1 <= s_tdata[NB-1:ID_BITS];
			ack_s1  <= s_tdata[NB];
			rdy_s1  <= s_tdata[NB+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[hsfs_pkg::CFG_ACK_TIMEOUT]   <= hsfs_pkg::ACK_TIMEOUT_RST;
			cfg_q[hsfs_pkg::CFG_RESET_LOW]     <= hsfs_pkg::RESET_LOW_RST;
			cfg_q[hsfs_pkg::CFG_RESET_RECOVER] <= hsfs_pkg::RESET_RECOVER_RST;
			cfg_q[hsfs_pkg::CFG_LATCH_HOLD]    <= hsfs_pkg::LATCH_HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// cursor bookkeeping shared by the read-ahead and the step
	assign last      = ((CW'(cursor_q) + 1'b1) >= count_q);
	assign bit_inc   = bit_q + 1'b1;
	assign bit_limit = BW'(NB) - BW'(last);
	assign bit_more  = (bit_inc < bit_limit);

	// read ahead the entry whose bit the coming step may put on the data line
	always_comb begin
		if (phase_q == hsfs_pkg::PH_WAIT_READY) begin
			rd_addr = '0;
		end else if (phase_q == hsfs_pkg::PH_ACK_LOW && !bit_more && !last) begin
			rd_addr = cursor_q + 1'b1;
		end else begin
			rd_addr = cursor_q;
		end
	end

	assign ram_we = exec_go && (phase_q == hsfs_pkg::PH_IDLE) && (op_s1 == hsfs_pkg::OP_LOAD)
		&& (count_q < CW'(MAX_ENTRIES));

	hsfs_entry_ram #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(NB),
		.AW   (AW)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(AW'(count_q)),
		.wr_data({time_s1, id_s1}),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_word)
	);

	// wait and delay evaluation
	always_comb begin
		case (phase_q)
			hsfs_pkg::PH_RESET_LOW:   lim = cfg_q[hsfs_pkg::CFG_RESET_LOW];
			hsfs_pkg::PH_RECOVER:     lim = cfg_q[hsfs_pkg::CFG_RESET_RECOVER];
			hsfs_pkg::PH_LATCH_HOLD:  lim = cfg_q[hsfs_pkg::CFG_LATCH_HOLD];
			default:                  lim = cfg_q[hsfs_pkg::CFG_ACK_TIMEOUT];
		endcase
	end

	assign sample  = (phase_q inside {hsfs_pkg::PH_WAIT_READY, hsfs_pkg::PH_WAIT_DONE})
		? rdy_s1 : ack_s1;
	assign want    = (phase_q inside {hsfs_pkg::PH_ACK_HIGH, hsfs_pkg::PH_FINAL_RISE,
		hsfs_pkg::PH_WAIT_DONE});
	assign hit     = (sample == want);
	assign cnt_inc = {1'b0, wait_q} + 1'b1;
	assign expire  = (cnt_inc >= {1'b0, lim});

	// bit index the step moves to, and its level
	always_comb begin
		if (phase_q == hsfs_pkg::PH_WAIT_READY) begin
			bit_new = '0;
		end else if (bit_more) begin
			bit_new = bit_inc;
		end else if (!last) begin
			bit_new = '0;
		end else begin
			bit_new = BW'(NB - 1);
		end
	end

	assign new_bit_val = rd_word[bit_new[BIW-1:0]];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (exec_go) begin
			if (is_tick) begin
				case (phase_q)
					hsfs_pkg::PH_WAIT_READY: begin
						if (hit) phase_d = hsfs_pkg::PH_ACK_HIGH;
						else if (expire) phase_d = retried_q ? hsfs_pkg::PH_IDLE
							: hsfs_pkg::PH_RESET_LOW;
					end
					hsfs_pkg::PH_RESET_LOW: begin
						if (expire) phase_d = hsfs_pkg::PH_RECOVER;
					end
					hsfs_pkg::PH_RECOVER: begin
						if (expire) phase_d = hsfs_pkg::PH_WAIT_READY;
					end
					hsfs_pkg::PH_ACK_HIGH: begin
						if (hit) phase_d = hsfs_pkg::PH_ACK_LOW;
						else if (expire) phase_d = hsfs_pkg::PH_IDLE;
					end
					hsfs_pkg::PH_ACK_LOW: begin
						if (hit) phase_d = (bit_more || !last) ? hsfs_pkg::PH_ACK_HIGH
							: hsfs_pkg::PH_FINAL_RISE;
						else if (expire) phase_d = hsfs_pkg::PH_IDLE;
					end
					hsfs_pkg::PH_FINAL_RISE: begin
						if (hit) phase_d = hsfs_pkg::PH_LATCH_HOLD;
						else if (expire) phase_d = hsfs_pkg::PH_IDLE;
					end
					hsfs_pkg::PH_LATCH_HOLD: begin
						if (expire) phase_d = hsfs_pkg::PH_FINAL_FALL;
					end
					hsfs_pkg::PH_FINAL_FALL: begin
						if (hit) phase_d = hsfs_pkg::PH_WAIT_DONE;
						else if (expire) phase_d = hsfs_pkg::PH_IDLE;
					end
					hsfs_pkg::PH_WAIT_DONE: begin
						if (hit || expire) phase_d = hsfs_pkg::PH_IDLE;
					end
					default: phase_d = phase_q;
				endcase
			end else if (phase_q == hsfs_pkg::PH_IDLE && op_s1 == hsfs_pkg::OP_START
				&& count_q != '0) begin
				phase_d = hsfs_pkg::PH_WAIT_READY;
			end
		end
	end

	// lines, counters and status
	always_comb begin
		count_d   = count_q;
		cursor_d  = cursor_q;
		bit_d     = bit_q;
		wait_d    = wait_q;
		retried_d = retried_q;
		clk_d     = clk_q;
		dat_d     = dat_q;
		req_d     = req_q;
		rst_d     = rst_q;
		status_d  = status_q;
		fail_e_d  = fail_e_q;
		fail_b_d  = fail_b_q;
		done_d    = done_q;
		if (exec_go) begin
			done_d = 1'b0;
			if (is_tick) begin
				case (phase_q)
					hsfs_pkg::PH_WAIT_READY: begin
						if (hit) begin
							cursor_d = '0;
							bit_d    = '0;
							dat_d    = new_bit_val;
							clk_d    = 1'b1;
							wait_d   = '0;
						end else if (expire) begin
							req_d = 1'b0;
							if (retried_q) begin
								status_d = hsfs_pkg::ST_READY_TIMEOUT;
								fail_e_d = '0;
								fail_b_d = '0;
								done_d   = 1'b1;
							end else begin
								rst_d  = 1'b0;
								wait_d = '0;
							end
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					hsfs_pkg::PH_RESET_LOW: begin
						if (expire) begin
							rst_d  = 1'b1;
							wait_d = '0;
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					hsfs_pkg::PH_RECOVER: begin
						if (expire) begin
							req_d     = 1'b1;
							retried_d = 1'b1;
							wait_d    = '0;
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					hsfs_pkg::PH_ACK_HIGH, hsfs_pkg::PH_ACK_LOW: begin
						if (hit) begin
							wait_d = '0;
							if (phase_q == hsfs_pkg::PH_ACK_HIGH) begin
								clk_d = 1'b0;
							end else begin
								// next bit, next entry or the final latch bit
								bit_d = bit_new;
								dat_d = new_bit_val;
								clk_d = 1'b1;
								if (!bit_more && !last) begin
									cursor_d = cursor_q + 1'b1;
								end
							end
						end else if (expire) begin
							clk_d    = 1'b0;
							req_d    = 1'b0;
							fail_e_d = hsfs_pkg::FAIL_E_W'(cursor_q);
							done_d   = 1'b1;
							if (bit_q < BW'(ID_BITS)) begin
								status_d = hsfs_pkg::ST_ID_BIT;
								fail_b_d = hsfs_pkg::FAIL_B_W'(bit_q);
							end else begin
								status_d = hsfs_pkg::ST_TIME_BIT;
								fail_b_d = hsfs_pkg::FAIL_B_W'(bit_q - BW'(ID_BITS));
							end
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					hsfs_pkg::PH_FINAL_RISE: begin
						if (hit) begin
							req_d  = 1'b0;
							wait_d = '0;
						end else if (expire) begin
							clk_d    = 1'b0;
							req_d    = 1'b0;
							status_d = hsfs_pkg::ST_FINAL_RISE;
							fail_e_d = hsfs_pkg::FAIL_E_W'(cursor_q);
							fail_b_d = hsfs_pkg::FAIL_B_W'(TIME_BITS - 1);
							done_d   = 1'b1;
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					hsfs_pkg::PH_LATCH_HOLD: begin
						if (expire) begin
							clk_d  = 1'b0;
							wait_d = '0;
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					hsfs_pkg::PH_FINAL_FALL: begin
						if (hit) begin
							wait_d = '0;
						end else if (expire) begin
							status_d = hsfs_pkg::ST_FINAL_FALL;
							fail_e_d = hsfs_pkg::FAIL_E_W'(cursor_q);
							fail_b_d = hsfs_pkg::FAIL_B_W'(TIME_BITS - 1);
							done_d   = 1'b1;
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					hsfs_pkg::PH_WAIT_DONE: begin
						if (hit) begin
							status_d = hsfs_pkg::ST_OK;
							fail_e_d = '0;
							fail_b_d = '0;
							done_d   = 1'b1;
						end else if (expire) begin
							status_d = hsfs_pkg::ST_COMPLETION;
							fail_e_d = hsfs_pkg::FAIL_E_W'(cursor_q);
							fail_b_d = hsfs_pkg::FAIL_B_W'(TIME_BITS - 1);
							done_d   = 1'b1;
						end else begin
							wait_d = cnt_inc[hsfs_pkg::CFG_W-1:0];
						end
					end
					default: begin
						wait_d = wait_q;
					end
				endcase
			end else if (phase_q == hsfs_pkg::PH_IDLE) begin
				case (op_s1)
					hsfs_pkg::OP_LOAD: begin
						if (ram_we) count_d = count_q + 1'b1;
					end
					hsfs_pkg::OP_CLEAR: begin
						count_d = '0;
					end
					hsfs_pkg::OP_START: begin
						if (count_q == '0) begin
							status_d = hsfs_pkg::ST_EMPTY;
							fail_e_d = '0;
							fail_b_d = '0;
							done_d   = 1'b1;
						end else begin
							status_d  = hsfs_pkg::ST_OK;
							fail_e_d  = '0;
							fail_b_d  = '0;
							dat_d     = 1'b0;
							clk_d     = 1'b0;
							req_d     = 1'b1;
							retried_d = 1'b0;
							wait_d    = '0;
						end
					end
					default: begin
						count_d = count_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hsfs_pkg::PH_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			bit_q       <= '0;
			wait_q      <= '0;
			retried_q   <= 1'b0;
			clk_q       <= 1'b0;
			dat_q       <= 1'b0;
			req_q       <= 1'b0;
			rst_q       <= 1'b1;
			status_q    <= hsfs_pkg::ST_OK;
			fail_e_q    <= '0;
			fail_b_q    <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			cursor_q  <= cursor_d;
			bit_q     <= bit_d;
			wait_q    <= wait_d;
			retried_q <= retried_d;
			clk_q     <= clk_d;
			dat_q     <= dat_d;
			req_q     <= req_d;
			rst_q     <= rst_d;
			status_q  <= status_d;
			fail_e_q  <= fail_e_d;
			fail_b_q  <= fail_b_d;
			done_q    <= done_d;
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// state only moves when a result is produced, so it doubles as the result
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {fail_b_q, fail_e_q, status_q, done_q, (phase_q != hsfs_pkg::PH_IDLE),
		rst_q, req_q, dat_q, clk_q};

	`HSFS_ASSERT_NEXT(a_done_on_finish,
		exec_go && phase_q != hsfs_pkg::PH_IDLE && phase_d == hsfs_pkg::PH_IDLE,
		done_q, "transfer ended without done pulse")
	`HSFS_ASSERT_NOW(a_reset_line_phase, !rst_q,
		phase_q == hsfs_pkg::PH_RESET_LOW, "reset line low outside reset phase")
	`HSFS_ASSERT_NOW(a_clock_high_phase, clk_q,
		phase_q == hsfs_pkg::PH_ACK_HIGH || phase_q == hsfs_pkg::PH_FINAL_RISE ||
		phase_q == hsfs_pkg::PH_LATCH_HOLD, "link clock high in wrong phase")
	`HSFS_ASSERT_NOW(a_load_only_idle, ram_we,
		phase_q == hsfs_pkg::PH_IDLE, "entry written during a transfer")
	`HSFS_ASSERT_NEXT(a_hold_while_stalled, m_tvalid && !m_tready,
		$stable(phase_q) && $stable(wait_q) && $stable(bit_q), "state moved under stall")

endmodule
